### design/tsu_pkg.sv
// ----------------------------------------------------------------------------
// tsu_pkg
// Shared types, constants and tables for the timestamp to Unix seconds pipe.
// ----------------------------------------------------------------------------
`default_nettype none

package tsu_pkg;

   localparam int NUM_STAGES = 6;

   localparam int YEAR_W = 14;
   localparam int SECS_W = 39;

   localparam logic [13:0] YEAR_BASE    = 14'd1900;
   localparam logic [25:0] RECIP_400    = 26'd5243;   // 2^21 / 400, rounded up
   localparam int          RECIP_SHIFT  = 21;
   localparam logic [13:0] RECIP_100    = 14'd41;     // 2^12 / 100, rounded up
   localparam logic signed [22:0] ERA_DAYS    = 23'sd146097;
   localparam logic signed [22:0] EPOCH_SHIFT = 23'sd719468;
   localparam logic signed [39:0] SECS_PER_DAY = 40'sd86400;

   localparam logic OP_SHORT = 1'b0;
   localparam logic OP_LONG  = 1'b1;

   typedef struct packed {
      logic              ok;
      logic [13:0]       year;
      logic [3:0]        month;
      logic [4:0]        day;
      logic [4:0]        hour;
      logic [5:0]        minute;
      logic [5:0]        second;
      logic signed [7:0] offset;
   } parse_type;

   typedef struct packed {
      logic               ok;
      logic signed [14:0] year_adj;
      logic [25:0]        quot;
      logic signed [9:0]  doy;
      logic [4:0]         hour;
      logic [5:0]         minute;
      logic [5:0]         second;
      logic signed [7:0]  offset;
   } quot_type;

   typedef struct packed {
      logic               ok;
      logic signed [5:0]  era;
      logic [8:0]         yoe;
      logic signed [9:0]  doy;
      logic [4:0]         hour;
      logic [5:0]         minute;
      logic [5:0]         second;
      logic signed [7:0]  offset;
   } era_type;

   typedef struct packed {
      logic               ok;
      logic signed [5:0]  era;
      logic signed [18:0] doe;
      logic signed [18:0] tod;
   } doe_type;

   typedef struct packed {
      logic               ok;
      logic signed [22:0] days;
      logic signed [18:0] tod;
   } days_type;

   // Days from March 1 to the first of the given month, March-based year.
   function automatic logic [8:0] month_base(input logic [3:0] month);
      logic [8:0] base;
      case (month)
         4'd0:    base = 9'd275;
         4'd1:    base = 9'd306;
         4'd2:    base = 9'd337;
         4'd3:    base = 9'd0;
         4'd4:    base = 9'd31;
         4'd5:    base = 9'd61;
         4'd6:    base = 9'd92;
         4'd7:    base = 9'd122;
         4'd8:    base = 9'd153;
         4'd9:    base = 9'd184;
         4'd10:   base = 9'd214;
         4'd11:   base = 9'd245;
         4'd12:   base = 9'd275;
         4'd13:   base = 9'd306;
         4'd14:   base = 9'd337;
         default: base = 9'd367;
      endcase
      return base;
   endfunction

endpackage

`default_nettype wire

### design/tsu_parse.sv
// ----------------------------------------------------------------------------
// tsu_parse
// Stage 1: selects the form, decodes and checks the ASCII digits.
// ----------------------------------------------------------------------------
`default_nettype none

module tsu_parse (
   input  wire logic               clock,
   input  wire logic               load,
   input  wire logic               operation,
   input  wire logic [7:0]         year_since_1900,
   input  wire logic [3:0]         month,
   input  wire logic [4:0]         day,
   input  wire logic [4:0]         hour,
   input  wire logic [5:0]         minute,
   input  wire logic [5:0]         second,
   input  wire logic [63:0]        date_text,
   input  wire logic [47:0]        clock_text,
   input  wire logic signed [7:0]  gmt_offset,
   output tsu_pkg::parse_type      stage_out
);

   tsu_pkg::parse_type stage_ff, stage_in;
   logic [13:0] chr_ok;
   logic [3:0]  chr_val [14];
   logic [6:0]  pair [7];
   logic [7:0]  chr;
   logic        digits_ok, range_ok;

   always_comb begin
      for (int i = 0; i < 14; i++) begin
         chr = (i < 8) ? date_text[8*i +: 8] : clock_text[8*(i-8) +: 8];
         chr_ok[i]  = (chr >= 8'h30) && (chr <= 8'h39);
         chr_val[i] = chr[3:0];
      end
      for (int j = 0; j < 7; j++) begin
         pair[j] = 7'(chr_val[2*j]) * 7'd10 + 7'(chr_val[2*j+1]);
      end
      digits_ok = &chr_ok;
      range_ok  = (pair[2] >= 7'd1) && (pair[2] <= 7'd12)
               && (pair[3] >= 7'd1) && (pair[3] <= 7'd31)
               && (pair[4] <= 7'd23) && (pair[5] <= 7'd59) && (pair[6] <= 7'd60);

      stage_in.offset = gmt_offset;
      if (operation == tsu_pkg::OP_LONG) begin
         stage_in.ok     = digits_ok && range_ok;
         stage_in.year   = 14'(pair[0]) * 14'd100 + 14'(pair[1]);
         stage_in.month  = pair[2][3:0];
         stage_in.day    = pair[3][4:0];
         stage_in.hour   = pair[4][4:0];
         stage_in.minute = pair[5][5:0];
         stage_in.second = pair[6][5:0];
      end else begin
         stage_in.ok     = 1'b1;
         stage_in.year   = 14'(year_since_1900) + tsu_pkg::YEAR_BASE;
         stage_in.month  = month;
         stage_in.day    = day;
         stage_in.hour   = hour;
         stage_in.minute = minute;
         stage_in.second = second;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in;
      end
   end

   assign stage_out = stage_ff;

endmodule

`default_nettype wire

### design/tsu_era.sv
// ----------------------------------------------------------------------------
// tsu_era
// Stages 2 and 3: March-based year, 400-year era and year of era.
// ----------------------------------------------------------------------------
`default_nettype none

module tsu_era (
   input  wire logic               clock,
   input  wire logic [1:0]         load,
   input  wire tsu_pkg::parse_type stage_in,
   output tsu_pkg::era_type        stage_out
);

   tsu_pkg::quot_type q_ff, q_in;
   tsu_pkg::era_type  e_ff, e_in;
   logic signed [15:0] yoe_full;

   always_comb begin
      q_in.ok       = stage_in.ok;
      q_in.year_adj = (stage_in.month <= 4'd2) ? $signed({1'b0, stage_in.year}) - 15'sd1
                                               : $signed({1'b0, stage_in.year});
      q_in.quot     = q_in.year_adj[14] ? '0
                                        : 26'(q_in.year_adj[13:0]) * tsu_pkg::RECIP_400;
      q_in.doy      = $signed({1'b0, tsu_pkg::month_base(stage_in.month)})
                    + $signed({5'b0, stage_in.day}) - 10'sd1;
      q_in.hour     = stage_in.hour;
      q_in.minute   = stage_in.minute;
      q_in.second   = stage_in.second;
      q_in.offset   = stage_in.offset;
   end

   always_comb begin
      e_in.ok     = q_ff.ok;
      e_in.era    = q_ff.year_adj[14] ? -6'sd1
                                      : $signed({1'b0, q_ff.quot[tsu_pkg::RECIP_SHIFT +: 5]});
      yoe_full    = 16'(q_ff.year_adj) - 16'(e_in.era) * 16'sd400;
      e_in.yoe    = yoe_full[8:0];
      e_in.doy    = q_ff.doy;
      e_in.hour   = q_ff.hour;
      e_in.minute = q_ff.minute;
      e_in.second = q_ff.second;
      e_in.offset = q_ff.offset;
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         q_ff <= q_in;
      end
      if (load[1]) begin
         e_ff <= e_in;
      end
   end

   assign stage_out = e_ff;

endmodule

`default_nettype wire

### design/tsu_accum.sv
// ----------------------------------------------------------------------------
// tsu_accum
// Stages 4 to 6: day of era and time of day, days from epoch, seconds.
// ----------------------------------------------------------------------------
`default_nettype none

module tsu_accum (
   input  wire logic                clock,
   input  wire logic [2:0]          load,
   input  wire tsu_pkg::era_type    stage_in,
   output logic signed [tsu_pkg::SECS_W-1:0] unix_seconds,
   output logic                     valid_res
);

   tsu_pkg::doe_type  d_ff, d_in;
   tsu_pkg::days_type n_ff, n_in;
   logic signed [tsu_pkg::SECS_W-1:0] unix_seconds_ff, unix_seconds_in;
   logic valid_res_ff;
   logic [13:0] c100_prod;
   logic [18:0] tod_pos;
   logic signed [18:0] tod_off;
   logic signed [39:0] secs_full;

   always_comb begin
      c100_prod = 14'(stage_in.yoe) * tsu_pkg::RECIP_100;
      d_in.ok   = stage_in.ok;
      d_in.era  = stage_in.era;
      d_in.doe  = $signed(19'(stage_in.yoe) * 19'd365 + 19'(stage_in.yoe[8:2])
                          - 19'(c100_prod[13:12])) + 19'(stage_in.doy);
      tod_pos   = 19'(stage_in.hour) * 19'd3600 + 19'(stage_in.minute) * 19'd60
                + 19'(stage_in.second);
      tod_off   = 19'(stage_in.offset) * 19'sd900;
      d_in.tod  = $signed(tod_pos) - tod_off;
   end

   always_comb begin
      n_in.ok   = d_ff.ok;
      n_in.days = 23'(d_ff.era) * tsu_pkg::ERA_DAYS + 23'(d_ff.doe) - tsu_pkg::EPOCH_SHIFT;
      n_in.tod  = d_ff.tod;
   end

   always_comb begin
      secs_full       = 40'(n_ff.days) * tsu_pkg::SECS_PER_DAY + 40'(n_ff.tod);
      unix_seconds_in = n_ff.ok ? secs_full[tsu_pkg::SECS_W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (load[0]) begin
         d_ff <= d_in;
      end
      if (load[1]) begin
         n_ff <= n_in;
      end
      if (load[2]) begin
         unix_seconds_ff <= unix_seconds_in;
         valid_res_ff    <= n_ff.ok;
      end
   end

   assign unix_seconds = unix_seconds_ff;
   assign valid_res    = valid_res_ff;

endmodule

`default_nettype wire

### design/iso9660_timestamp_to_unix_top.sv
// ----------------------------------------------------------------------------
// iso9660_timestamp_to_unix_top
// ISO 9660 short or long timestamp to signed Unix seconds, six-stage pipe.
// ----------------------------------------------------------------------------
//  channel  direction  handshake           payload
//  req_     in         req_valid/req_stall operation, short fields, text, offset
//  rsp_     out        rsp_valid/rsp_stall unix_seconds, valid_res
//
//  One beat in per cycle while req_stall is low. The stage chain is:
//  parse, era quotient, era/yoe, day of era, days from epoch,
//  multiply by 86400.
//  Each stage loads when empty or when the stage after it moves, so
//  bubbles close up under rsp_stall; a stalled result holds its value.
//  Synchronous reset empties every stage.
// ----------------------------------------------------------------------------
`default_nettype none

module iso9660_timestamp_to_unix_top (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_operation,
   input  wire logic [7:0]         req_year_since_1900,
   input  wire logic [3:0]         req_month,
   input  wire logic [4:0]         req_day,
   input  wire logic [4:0]         req_hour,
   input  wire logic [5:0]         req_minute,
   input  wire logic [5:0]         req_second,
   input  wire logic [63:0]        req_date_text,
   input  wire logic [47:0]        req_clock_text,
   input  wire logic signed [7:0]  req_gmt_offset,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic signed [38:0]      rsp_unix_seconds,
   output logic                    rsp_valid_res
);

   localparam int N = tsu_pkg::NUM_STAGES;

   logic [N-1:0] valid_ff, valid_in, load;
   tsu_pkg::parse_type s1;
   tsu_pkg::era_type   s3;

   always_comb begin
      load[N-1] = !valid_ff[N-1] || !rsp_stall;
      for (int k = N - 2; k >= 0; k--) begin
         load[k] = !valid_ff[k] || load[k+1];
      end
      for (int k = 0; k < N; k++) begin
         if (load[k]) begin
            valid_in[k] = (k == 0) ? req_valid : valid_ff[(k == 0) ? 0 : k - 1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_stall = !load[0];
   assign rsp_valid = valid_ff[N-1];

   tsu_parse u_parse (
      .clock           (clock),
      .load            (load[0]),
      .operation       (req_operation),
      .year_since_1900 (req_year_since_1900),
      .month           (req_month),
      .day             (req_day),
      .hour            (req_hour),
      .minute          (req_minute),
      .second          (req_second),
      .date_text       (req_date_text),
      .clock_text      (req_clock_text),
      .gmt_offset      (req_gmt_offset),
      .stage_out       (s1)
   );

   tsu_era u_era (
      .clock     (clock),
      .load      (load[2:1]),
      .stage_in  (s1),
      .stage_out (s3)
   );

   tsu_accum u_accum (
      .clock        (clock),
      .load         (load[5:3]),
      .stage_in     (s3),
      .unix_seconds (rsp_unix_seconds),
      .valid_res    (rsp_valid_res)
   );

endmodule

`default_nettype wire

### design/tsu_checker.sv
// ----------------------------------------------------------------------------
// tsu_checker
// Port-level checks on the timestamp pipe, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tsu_checker (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_stall,
   input wire logic               rsp_valid,
   input wire logic               rsp_stall,
   input wire logic signed [38:0] rsp_unix_seconds,
   input wire logic               rsp_valid_res
);

   // failed conversion carries zero seconds
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> rsp_unix_seconds == 39'sd0)
      else $error("invalid beat with non-zero seconds");

   // with the output free every stage can move, so input is never held
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("input stalled while output empty");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat straight after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_unix_seconds))
      else $error("stalled result beat changed");

endmodule

bind iso9660_timestamp_to_unix_top tsu_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_unix_seconds (rsp_unix_seconds),
   .rsp_valid_res    (rsp_valid_res)
);

`default_nettype wire
